### rtl/otp_pkg.sv
package otp_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int MAX_RESULTS = 8;

  localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W = 32;
  localparam int TAG_W   = 8;
  localparam int SLOT_W  = 8;
  localparam int RAM_W   = TAG_W + COUNT_W;

  localparam logic [SLOT_W-1:0] NO_SLOT = 8'hFF;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_EXPIRY  = 3'd0,
    KIND_STARTED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_ZERO    = 3'd3,
    KIND_STOPPED = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_TICK,
    ST_TICK_END
  } state_t;

  typedef struct packed {
    logic             set_en;
    logic [IDX_W-1:0] set_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
  } slot_cmd_t;

  typedef struct packed {
    logic [NUM_TIMERS-1:0] active;
    logic [NUM_TIMERS-1:0] written;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
  } slot_stat_t;

endpackage

### rtl/otp_ram.sv
module otp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/otp_slots.sv
module otp_slots (
  input  logic               clk,
  input  logic               rst_n,
  input  otp_pkg::slot_cmd_t cmd,
  output otp_pkg::slot_stat_t stat
);

  logic [otp_pkg::NUM_TIMERS-1:0] active_r;
  logic [otp_pkg::NUM_TIMERS-1:0] active_nxt;
  logic [otp_pkg::NUM_TIMERS-1:0] written_r;
  logic [otp_pkg::NUM_TIMERS-1:0] written_nxt;
  logic                           free_found;
  logic [otp_pkg::IDX_W-1:0]      free_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      written_r <= '0;
    end else begin
      active_r  <= active_nxt;
      written_r <= written_nxt;
    end
  end

  always_comb begin
    active_nxt  = active_r;
    written_nxt = written_r;
    if (cmd.clr_en) begin
      active_nxt[cmd.clr_idx] = 1'b0;
    end
    if (cmd.set_en) begin
      active_nxt[cmd.set_idx]  = 1'b1;
      written_nxt[cmd.set_idx] = 1'b1;
    end
  end

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = otp_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = otp_pkg::IDX_W'(i);
      end
    end
  end

  assign stat.active     = active_r;
  assign stat.written    = written_r;
  assign stat.free_found = free_found;
  assign stat.free_idx   = free_idx;

endmodule

### rtl/one_shot_timer_pool_top.sv
// Pool of one-shot countdown timers. A word is taken when start is high and busy is low;
// in_action selects tick, start, stop or query. Start and stop answer in the next cycle,
// query after one read of the count memory (ST_QUERY, then the output register). A tick sweeps
// the slots through the count/tag memory one slot per cycle and holds busy while it reads
// every slot, does the last update and sends the final expiry; each expiry leaves as
// its own word in index order, out_last marks the final word of an item, and a tick with no
// expiry gives no word. Results are shown for one cycle under out_valid and cannot be stalled.
module one_shot_timer_pool_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [31:0]                  in_delay_ms,
  input  logic [7:0]                   in_callback_tag,
  input  logic [7:0]                   in_timer_index,
  output logic                         out_valid,
  output logic [2:0]                   out_result_kind,
  output logic [7:0]                   out_slot,
  output logic [7:0]                   out_tag,
  output logic                         out_expired,
  output logic                         out_last
);

  otp_pkg::state_t                state_r, state_nxt;
  logic [otp_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           pv_r, pv_nxt;
  logic [otp_pkg::IDX_W-1:0]      pidx_r, pidx_nxt;
  logic [otp_pkg::RES_W-1:0]      nrep_r, nrep_nxt;
  logic                           pend_v_r, pend_v_nxt;
  logic [otp_pkg::IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic [otp_pkg::TAG_W-1:0]      pend_tag_r, pend_tag_nxt;
  logic [otp_pkg::SLOT_W-1:0]     q_idx_r, q_idx_nxt;

  logic                           ov_r, ov_nxt;
  otp_pkg::kind_t                 okind_r, okind_nxt;
  logic [otp_pkg::SLOT_W-1:0]     oslot_r, oslot_nxt;
  logic [otp_pkg::TAG_W-1:0]      otag_r, otag_nxt;
  logic                           oexp_r, oexp_nxt;
  logic                           olast_r, olast_nxt;

  logic                           ram_we;
  logic [otp_pkg::IDX_W-1:0]      ram_waddr;
  logic [otp_pkg::RAM_W-1:0]      ram_wdata;
  logic [otp_pkg::IDX_W-1:0]      ram_raddr;
  logic [otp_pkg::RAM_W-1:0]      ram_rdata;

  otp_pkg::slot_cmd_t             scmd;
  otp_pkg::slot_stat_t            sstat;

  otp_pkg::action_t               act;
  logic                           accept;
  logic                           in_idx_ok;
  logic                           q_idx_ok;
  logic [otp_pkg::COUNT_W-1:0]    rd_count;
  logic [otp_pkg::COUNT_W-1:0]    dec_count;
  logic [otp_pkg::TAG_W-1:0]      rd_tag;

  otp_ram #(
    .WIDTH (otp_pkg::RAM_W),
    .DEPTH (otp_pkg::NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  otp_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (scmd),
    .stat  (sstat)
  );

  assign act       = otp_pkg::action_t'(in_action);
  assign busy      = (state_r != otp_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign in_idx_ok = in_timer_index < otp_pkg::SLOT_W'(otp_pkg::NUM_TIMERS);
  assign q_idx_ok  = q_idx_r < otp_pkg::SLOT_W'(otp_pkg::NUM_TIMERS);
  assign rd_tag    = ram_rdata[otp_pkg::RAM_W-1:otp_pkg::COUNT_W];
  assign dec_count = rd_count - otp_pkg::COUNT_W'(1);

  // never-written entry reads as zero count
  always_comb begin
    rd_count = '0;
    if (state_r == otp_pkg::ST_QUERY) begin
      if (sstat.written[q_idx_r[otp_pkg::IDX_W-1:0]]) begin
        rd_count = ram_rdata[otp_pkg::COUNT_W-1:0];
      end
    end else if (sstat.written[pidx_r]) begin
      rd_count = ram_rdata[otp_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= otp_pkg::ST_IDLE;
      ov_r     <= 1'b0;
      pv_r     <= 1'b0;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
      nrep_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      pv_r     <= pv_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
      nrep_r   <= nrep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    q_idx_r    <= q_idx_nxt;
    okind_r    <= okind_nxt;
    oslot_r    <= oslot_nxt;
    otag_r     <= otag_nxt;
    oexp_r     <= oexp_nxt;
    olast_r    <= olast_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    nrep_nxt     = nrep_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_tag_nxt = pend_tag_r;
    q_idx_nxt    = q_idx_r;

    ov_nxt    = 1'b0;
    okind_nxt = okind_r;
    oslot_nxt = oslot_r;
    otag_nxt  = '0;
    oexp_nxt  = 1'b0;
    olast_nxt = 1'b1;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    scmd      = '0;

    case (state_r)
      otp_pkg::ST_IDLE: begin
        if (accept) begin
          case (act)
            otp_pkg::ACT_TICK: begin
              state_nxt  = otp_pkg::ST_TICK;
              cnt_nxt    = '0;
              nrep_nxt   = '0;
              pend_v_nxt = 1'b0;
            end
            otp_pkg::ACT_START: begin
              ov_nxt = 1'b1;
              if (in_delay_ms == '0) begin
                okind_nxt = otp_pkg::KIND_ZERO;
                oslot_nxt = otp_pkg::NO_SLOT;
              end else if (!sstat.free_found) begin
                okind_nxt = otp_pkg::KIND_FULL;
                oslot_nxt = otp_pkg::NO_SLOT;
              end else begin
                okind_nxt    = otp_pkg::KIND_STARTED;
                oslot_nxt    = otp_pkg::SLOT_W'(sstat.free_idx);
                ram_we       = 1'b1;
                ram_waddr    = sstat.free_idx;
                ram_wdata    = {in_callback_tag, in_delay_ms};
                scmd.set_en  = 1'b1;
                scmd.set_idx = sstat.free_idx;
              end
            end
            otp_pkg::ACT_STOP: begin
              ov_nxt       = 1'b1;
              okind_nxt    = otp_pkg::KIND_STOPPED;
              oslot_nxt    = in_timer_index;
              scmd.clr_en  = in_idx_ok;
              scmd.clr_idx = in_timer_index[otp_pkg::IDX_W-1:0];
            end
            otp_pkg::ACT_QUERY: begin
              state_nxt = otp_pkg::ST_QUERY;
              q_idx_nxt = in_timer_index;
              ram_raddr = in_timer_index[otp_pkg::IDX_W-1:0];
            end
            default: begin
              state_nxt = otp_pkg::ST_IDLE;
            end
          endcase
        end
      end

      otp_pkg::ST_QUERY: begin
        ov_nxt    = 1'b1;
        okind_nxt = otp_pkg::KIND_QUERY;
        oslot_nxt = q_idx_r;
        oexp_nxt  = q_idx_ok && (rd_count == '0);
        state_nxt = otp_pkg::ST_IDLE;
      end

      otp_pkg::ST_TICK: begin
        // read slot cnt_r while slot pidx_r is updated
        if (cnt_r != otp_pkg::CNT_W'(otp_pkg::NUM_TIMERS)) begin
          ram_raddr = cnt_r[otp_pkg::IDX_W-1:0];
          pv_nxt    = 1'b1;
          pidx_nxt  = cnt_r[otp_pkg::IDX_W-1:0];
          cnt_nxt   = cnt_r + otp_pkg::CNT_W'(1);
        end else begin
          state_nxt = otp_pkg::ST_TICK_END;
        end
        if (pv_r && sstat.active[pidx_r] && (rd_count != '0)) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_r;
          ram_wdata = {rd_tag, dec_count};
          if (dec_count == '0) begin
            scmd.clr_en  = 1'b1;
            scmd.clr_idx = pidx_r;
            if (nrep_r != otp_pkg::RES_W'(otp_pkg::MAX_RESULTS)) begin
              nrep_nxt     = nrep_r + otp_pkg::RES_W'(1);
              pend_v_nxt   = 1'b1;
              pend_idx_nxt = pidx_r;
              pend_tag_nxt = rd_tag;
              if (pend_v_r) begin
                ov_nxt    = 1'b1;
                okind_nxt = otp_pkg::KIND_EXPIRY;
                oslot_nxt = otp_pkg::SLOT_W'(pend_idx_r);
                otag_nxt  = pend_tag_r;
                olast_nxt = 1'b0;
              end
            end
          end
        end
      end

      otp_pkg::ST_TICK_END: begin
        ov_nxt     = pend_v_r;
        okind_nxt  = otp_pkg::KIND_EXPIRY;
        oslot_nxt  = otp_pkg::SLOT_W'(pend_idx_r);
        otag_nxt   = pend_tag_r;
        pend_v_nxt = 1'b0;
        state_nxt  = otp_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = otp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = ov_r;
  assign out_result_kind = okind_r;
  assign out_slot        = oslot_r;
  assign out_tag         = otag_r;
  assign out_expired     = oexp_r;
  assign out_last        = olast_r;

  a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != otp_pkg::KIND_EXPIRY) |-> out_last)
    else $error("non-expiry word without last");

  a_expiry_slot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == otp_pkg::KIND_EXPIRY)
      |-> out_slot < otp_pkg::SLOT_W'(otp_pkg::NUM_TIMERS))
    else $error("expiry from slot out of range");

  a_cmd_answer : assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((act == otp_pkg::ACT_START) || (act == otp_pkg::ACT_STOP))
      |=> out_valid && out_last)
    else $error("start or stop not answered next cycle");

  a_query_answer : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (act == otp_pkg::ACT_QUERY)
      |=> ##1 out_valid && (out_result_kind == otp_pkg::KIND_QUERY))
    else $error("query not answered");

  a_expired_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expired |-> out_result_kind == otp_pkg::KIND_QUERY)
    else $error("expired flag outside query answer");

  a_no_expiry_write_clash : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && (state_r == otp_pkg::ST_TICK) |-> sstat.written[ram_waddr])
    else $error("tick updated a never-started slot");

endmodule
